// File: rtl/dbrs_pkg.sv
// Shared types, codes and defaults of the deadline batch request scheduler.
package dbrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 8;

    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int EXPIRE_W  = 20;
    localparam int LIMIT_W   = 16;
    localparam int CFG_DW    = 20;
    localparam int CFG_AW    = 2;
    localparam int TIME_W    = 32;
    localparam int BATCH_W   = 17;

    localparam logic [EXPIRE_W-1:0] READ_EXPIRE_RST  = EXPIRE_W'(25);
    localparam logic [EXPIRE_W-1:0] WRITE_EXPIRE_RST = EXPIRE_W'(200);
    localparam logic [LIMIT_W-1:0]  BATCH_LIMIT_RST  = LIMIT_W'(16);
    localparam logic [BATCH_W-1:0]  BATCH_MAX        = '1;

    localparam logic [CFG_AW-1:0] REG_READ_EXPIRE  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WRITE_EXPIRE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_BATCH_LIMIT  = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted transaction
        logic exec;   // carry it out and post the result
    } dbrs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_full;   // a result waits in the output register
    } dbrs_stat_t;

endpackage

// File: rtl/deadline_batch_request_scheduler_unit.sv
// Top level of the deadline batch request scheduler: controller plus datapath.
//
// Deadline batch request scheduler. Keeps a read FIFO and a write FIFO of
// request tags, each tag stamped with a deadline of now plus that
// direction's expiry (32-bit wrapping time). Each input transaction is one
// action: add a tag (status 3 if that FIFO is full), advance time by one
// tick, or dispatch one tag. A dispatch serves the read head first, then
// the write head; once the batch count exceeds batch_limit the count is
// cleared and expired heads take priority, the earlier deadline winning
// when both have expired (a read wins a tie). Every transaction returns
// exactly one result transaction. Each transaction is first captured while
// the FIFO head entries are read out of memory into registers, then
// executed: deadlines are compared and queues and counters updated.
// A new transaction is taken only after the last one has executed;
// a result left waiting in the output register holds the next transaction
// before it executes. s_ready stays low during reset and rises in the cycle
// after reset is released. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata with no handshake and must only change while
// the block is idle. The FIFO memories need no clearing after reset.
module deadline_batch_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = dbrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = dbrs_pkg::TAG_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [dbrs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [dbrs_pkg::CFG_DW-1:0]     cfg_wdata,
    // request transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dbrs_pkg::ACTION_W-1:0]   s_action,
    input  logic                            s_is_write,
    input  logic [TAG_BITS-1:0]             s_request_tag,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dbrs_pkg::STATUS_W-1:0]   m_status,
    output logic [TAG_BITS-1:0]             m_out_tag,
    output logic                            m_out_is_write,
    output logic                            m_by_expiry
);
    import dbrs_pkg::*;

    dbrs_cmd_t  cmd;
    dbrs_stat_t stat;

    // Sequence each transaction: capture, then execute when the output is free
    dbrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold queues, time, batch count, registers and the result
    dbrs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_is_write     (s_is_write),
        .s_request_tag  (s_request_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_tag      (m_out_tag),
        .m_out_is_write (m_out_is_write),
        .m_by_expiry    (m_by_expiry),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

// File: rtl/dbrs_ctrl.sv
// Controller state machine of the deadline batch request scheduler.
module dbrs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               m_ready,
    input  dbrs_pkg::dbrs_stat_t stat,
    output dbrs_pkg::dbrs_cmd_t  cmd
);
    import dbrs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   out_free;

    assign s_ready  = s_ready_reg;
    assign out_free = !stat.out_full || m_ready;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load     = 1'b1;
                    state_next   = S_EXEC;
                    s_ready_next = 1'b0;
                end else begin
                    s_ready_next = 1'b1;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    state_next   = S_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = S_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

endmodule

// File: rtl/dbrs_dpath.sv
// Datapath of the deadline batch request scheduler: FIFO memories, counters, result.
module dbrs_dpath #(
    parameter int QUEUE_DEPTH = dbrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = dbrs_pkg::TAG_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dbrs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [dbrs_pkg::CFG_DW-1:0]     cfg_wdata,
    input  logic [dbrs_pkg::ACTION_W-1:0]   s_action,
    input  logic                            s_is_write,
    input  logic [TAG_BITS-1:0]             s_request_tag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dbrs_pkg::STATUS_W-1:0]   m_status,
    output logic [TAG_BITS-1:0]             m_out_tag,
    output logic                            m_out_is_write,
    output logic                            m_by_expiry,
    input  dbrs_pkg::dbrs_cmd_t             cmd,
    output dbrs_pkg::dbrs_stat_t            stat
);
    import dbrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // FIFO storage
    logic [TAG_BITS-1:0] rd_tag_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]   rd_dl_mem  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] wr_tag_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]   wr_dl_mem  [QUEUE_DEPTH];

    logic [TAG_BITS-1:0] rd_tag_q, wr_tag_q;
    logic [TIME_W-1:0]   rd_dl_q, wr_dl_q;

    logic [PTR_W-1:0] rd_head_reg, rd_head_next, rd_tail_reg, rd_tail_next;
    logic [PTR_W-1:0] wr_head_reg, wr_head_next, wr_tail_reg, wr_tail_next;
    logic [CNT_W-1:0] rd_count_reg, rd_count_next, wr_count_reg, wr_count_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;

    logic [EXPIRE_W-1:0] rd_expire_reg, wr_expire_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [ACTION_W-1:0] action_reg;
    logic                is_write_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TAG_BITS-1:0] otag_reg, otag_next;
    logic                owr_reg, owr_next;
    logic                oexp_reg, oexp_next;

    logic                rd_push, wr_push, rd_pop, wr_pop;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   rd_left, wr_left, dl_diff;
    logic                rd_expired, wr_expired, check;
    logic                pick_valid, pick_wr, by_exp;
    logic [BATCH_W-1:0]  batch_base;

    assign stat.out_full  = out_valid_reg;
    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_out_tag      = otag_reg;
    assign m_out_is_write = owr_reg;
    assign m_by_expiry    = oexp_reg;

    // Head reads, registered every cycle; heads are stable while a dispatch waits
    always_ff @(posedge aclk) begin
        rd_tag_q <= rd_tag_mem[rd_head_reg];
        rd_dl_q  <= rd_dl_mem[rd_head_reg];
        wr_tag_q <= wr_tag_mem[wr_head_reg];
        wr_dl_q  <= wr_dl_mem[wr_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (rd_push) begin
            rd_tag_mem[rd_tail_reg] <= tag_reg;
            rd_dl_mem[rd_tail_reg]  <= deadline;
        end
        if (wr_push) begin
            wr_tag_mem[wr_tail_reg] <= tag_reg;
            wr_dl_mem[wr_tail_reg]  <= deadline;
        end
    end

    always_comb begin
        deadline = now_reg + TIME_W'(is_write_reg ? wr_expire_reg : rd_expire_reg);
        rd_left  = rd_dl_q - now_reg;
        wr_left  = wr_dl_q - now_reg;
        dl_diff  = wr_dl_q - rd_dl_q;
        rd_expired = (rd_count_reg != '0) && rd_left[TIME_W-1];
        wr_expired = (wr_count_reg != '0) && wr_left[TIME_W-1];
        check      = batch_reg > BATCH_W'(limit_reg);

        pick_valid = 1'b0;
        pick_wr    = 1'b0;
        by_exp     = 1'b0;
        if (check && (rd_expired || wr_expired)) begin
            pick_valid = 1'b1;
            by_exp     = 1'b1;
            if (rd_expired && wr_expired) begin
                pick_wr = dl_diff[TIME_W-1];
            end else begin
                pick_wr = wr_expired;
            end
        end else if (rd_count_reg != '0) begin
            pick_valid = 1'b1;
        end else if (wr_count_reg != '0) begin
            pick_valid = 1'b1;
            pick_wr    = 1'b1;
        end

        batch_base = check ? '0 : batch_reg;

        rd_push     = 1'b0;
        wr_push     = 1'b0;
        rd_pop      = 1'b0;
        wr_pop      = 1'b0;
        now_next    = now_reg;
        batch_next  = batch_reg;
        status_next = STATUS_OK;
        otag_next   = '0;
        owr_next    = 1'b0;
        oexp_next   = 1'b0;

        if (cmd.exec) begin
            case (action_reg)
                ACT_ADD: begin
                    if (is_write_reg) begin
                        if (wr_count_reg == CNT_FULL) status_next = STATUS_FULL;
                        else wr_push = 1'b1;
                    end else begin
                        if (rd_count_reg == CNT_FULL) status_next = STATUS_FULL;
                        else rd_push = 1'b1;
                    end
                end
                ACT_DISPATCH: begin
                    batch_next = batch_base;
                    if (pick_valid) begin
                        status_next = STATUS_DISPATCHED;
                        owr_next    = pick_wr;
                        oexp_next   = by_exp;
                        otag_next   = pick_wr ? wr_tag_q : rd_tag_q;
                        rd_pop      = !pick_wr;
                        wr_pop      = pick_wr;
                        if (batch_base != BATCH_MAX) batch_next = batch_base + 1'b1;
                    end else begin
                        status_next = STATUS_EMPTY;
                    end
                end
                ACT_TICK: begin
                    now_next = now_reg + 1'b1;
                end
                default: begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        rd_head_next  = rd_pop  ? ((rd_head_reg == PTR_LAST) ? '0 : rd_head_reg + 1'b1)
                                : rd_head_reg;
        wr_head_next  = wr_pop  ? ((wr_head_reg == PTR_LAST) ? '0 : wr_head_reg + 1'b1)
                                : wr_head_reg;
        rd_tail_next  = rd_push ? ((rd_tail_reg == PTR_LAST) ? '0 : rd_tail_reg + 1'b1)
                                : rd_tail_reg;
        wr_tail_next  = wr_push ? ((wr_tail_reg == PTR_LAST) ? '0 : wr_tail_reg + 1'b1)
                                : wr_tail_reg;
        rd_count_next = rd_count_reg + CNT_W'(rd_push) - CNT_W'(rd_pop);
        wr_count_next = wr_count_reg + CNT_W'(wr_push) - CNT_W'(wr_pop);
    end

    // Captured transaction and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg   <= s_action;
            is_write_reg <= s_is_write;
            tag_reg      <= s_request_tag;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            otag_reg   <= otag_next;
            owr_reg    <= owr_next;
            oexp_reg   <= oexp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_head_reg   <= '0;
            rd_tail_reg   <= '0;
            rd_count_reg  <= '0;
            wr_head_reg   <= '0;
            wr_tail_reg   <= '0;
            wr_count_reg  <= '0;
            now_reg       <= '0;
            batch_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_expire_reg <= READ_EXPIRE_RST;
            wr_expire_reg <= WRITE_EXPIRE_RST;
            limit_reg     <= BATCH_LIMIT_RST;
        end else begin
            rd_head_reg  <= rd_head_next;
            rd_tail_reg  <= rd_tail_next;
            rd_count_reg <= rd_count_next;
            wr_head_reg  <= wr_head_next;
            wr_tail_reg  <= wr_tail_next;
            wr_count_reg <= wr_count_next;
            now_reg      <= now_next;
            batch_reg    <= batch_next;
            if (cmd.exec) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_READ_EXPIRE:  rd_expire_reg <= cfg_wdata[EXPIRE_W-1:0];
                    REG_WRITE_EXPIRE: wr_expire_reg <= cfg_wdata[EXPIRE_W-1:0];
                    REG_BATCH_LIMIT:  limit_reg     <= cfg_wdata[LIMIT_W-1:0];
                    default: begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
        end
    end

endmodule
